### rtl/core/ctue_pkg.sv
// Shared types and constants for the contact table upsert and evict unit.
`default_nettype none
package ctue_pkg;

	// Number of entries in the contact table.
	localparam int TABLE_DEPTH = 32;
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int ADDR_W      = 16;
	localparam int SLOT_W      = 5;

	typedef enum logic [1:0] {
		REQ_QUERY    = 2'd0,
		REQ_BLOCKED  = 2'd1,
		REQ_FAVORITE = 2'd2,
		REQ_ENSURE   = 2'd3
	} req_t;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic              blocked;
		logic              favorite;
	} entry_t;

endpackage
`default_nettype wire

### rtl/core/ctue_table_ram.sv
// Single-port-read, single-port-write entry memory with registered read data.
`default_nettype none
module ctue_table_ram (
	input  wire logic                  clk,
	input  wire logic                  rd_en,
	input  wire logic [ctue_pkg::IDX_W-1:0] rd_idx,
	output      ctue_pkg::entry_t       rd_data,
	input  wire logic                  wr_en,
	input  wire logic [ctue_pkg::IDX_W-1:0] wr_idx,
	input  wire ctue_pkg::entry_t       wr_data
);
	import ctue_pkg::*;

	entry_t mem [TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_idx];
		end
	end

endmodule
`default_nettype wire

### rtl/core/contact_table_upsert_evict_unit.sv
// Top level of the contact table: scan sequencer, result registers and entry memory.
// Each request scans the filled entries linearly through the single memory read port,
// so its run time grows with the fill count; with an empty table the scan is skipped
// and the sequencer goes straight from idle to the finish state.
// Requests are handled one at a time; a new start is taken in the cycle done is high.
// Reset clears the fill count and the sequencer; the memory itself is not cleared.
`default_nettype none
module contact_table_upsert_evict_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output      logic        busy,
	input  wire logic [1:0]  req_type,
	input  wire logic [15:0] addr,
	input  wire logic        flag_value,
	output      logic        done,
	output      logic        hit,
	output      logic        blocked_mark,
	output      logic        favorite_mark,
	output      logic [4:0]  slot,
	output      logic        inserted,
	output      logic        evicted,
	output      logic [15:0] evicted_addr
);
	import ctue_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FINISH} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   fill_q;
	logic [IDX_W-1:0]   rd_q;
	logic               issue_q;
	logic               vld_s1;
	logic [IDX_W-1:0]   idx_s1;

	// Request as captured by the accepting transfer.
	req_t               req_q;
	logic [ADDR_W-1:0]  addr_q;
	logic               flag_q;

	// Scan results: first matching entry and eviction victim.
	logic               hit_q;
	logic [IDX_W-1:0]   hidx_q;
	entry_t             hent_q;
	logic               vfound_q;
	logic [IDX_W-1:0]   vidx_q;
	entry_t             vent_q;

	entry_t             rd_data;
	logic               rd_en;
	logic               wr_en;
	logic [IDX_W-1:0]   wr_idx;
	entry_t             wr_data;
	logic               accept;
	logic               last_issue;
	logic               last_data;
	logic               full;

	assign busy       = (state_q != ST_IDLE);
	assign accept     = start && !busy;
	assign rd_en      = (state_q == ST_SCAN) && issue_q;
	assign full       = (fill_q == CNT_W'(TABLE_DEPTH));
	assign last_issue = (CNT_W'(rd_q) == fill_q - CNT_W'(1));
	assign last_data  = vld_s1 && (CNT_W'(idx_s1) == fill_q - CNT_W'(1));

	ctue_table_ram u_ram (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_idx  (rd_q),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_idx  (wr_idx),
		.wr_data (wr_data)
	);

	// Resolve the request once the scan is complete. A query writes nothing; for
	// the others, a hit updates the matching entry in place and a miss appends while
	// room remains, else replaces the victim. New entries start with both marks clear.
	logic              res_hit;
	logic              res_ins;
	logic              res_evc;
	logic [ADDR_W-1:0] res_old;
	entry_t            res_ent;
	logic [IDX_W-1:0]  res_idx;

	always_comb begin
		res_hit = hit_q;
		res_ins = 1'b0;
		res_evc = 1'b0;
		res_old = '0;
		res_idx = hidx_q;
		res_ent = hent_q;
		wr_en   = 1'b0;
		if (req_q == REQ_QUERY) begin
			if (!hit_q) begin
				res_idx = '0;
				res_ent = '0;
			end
		end else begin
			wr_en = (state_q == ST_FINISH);
			if (!hit_q) begin
				res_ent = '{addr: addr_q, blocked: 1'b0, favorite: 1'b0};
				if (!full) begin
					res_idx = fill_q[IDX_W-1:0];
					res_ins = 1'b1;
				end else begin
					res_idx = vidx_q;
					res_evc = 1'b1;
					res_old = vent_q.addr;
				end
			end
			case (req_q)
				REQ_BLOCKED:  res_ent.blocked  = flag_q;
				REQ_FAVORITE: res_ent.favorite = flag_q;
				default:      ;
			endcase
		end
		wr_idx  = res_idx;
		wr_data = res_ent;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			fill_q   <= '0;
			issue_q  <= 1'b0;
			vld_s1   <= 1'b0;
			done     <= 1'b0;
			hit_q    <= 1'b0;
			vfound_q <= 1'b0;
			rd_q     <= '0;
		end else begin
			done   <= 1'b0;
			vld_s1 <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						req_q    <= req_t'(req_type);
						addr_q   <= addr;
						flag_q   <= flag_value;
						hit_q    <= 1'b0;
						vfound_q <= 1'b0;
						hidx_q   <= '0;
						vidx_q   <= '0;
						rd_q     <= '0;
						if (fill_q == '0) begin
							state_q <= ST_FINISH;
						end else begin
							state_q <= ST_SCAN;
							issue_q <= 1'b1;
						end
					end
				end
				ST_SCAN: begin
					// Read issue side: one entry per cycle up to the fill count.
					if (issue_q) begin
						vld_s1 <= 1'b1;
						idx_s1 <= rd_q;
						if (last_issue) begin
							issue_q <= 1'b0;
						end else begin
							rd_q <= rd_q + IDX_W'(1);
						end
					end
					// Compare side: the memory registers the data for idx_s1 together with vld_s1 and idx_s1.
					if (vld_s1) begin
						if (!hit_q && (rd_data.addr == addr_q)) begin
							hit_q  <= 1'b1;
							hidx_q <= idx_s1;
							hent_q <= rd_data;
						end
						// Entry 0 is the fallback victim when every entry is a favorite.
						if (!vfound_q && ((idx_s1 == '0) || !rd_data.favorite)) begin
							vidx_q <= idx_s1;
							vent_q <= rd_data;
						end
						if (!rd_data.favorite) begin
							vfound_q <= 1'b1;
						end
						if (last_data) begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_FINISH: begin
					done          <= 1'b1;
					hit           <= res_hit;
					blocked_mark  <= res_ent.blocked;
					favorite_mark <= res_ent.favorite;
					slot          <= SLOT_W'(res_idx);
					inserted      <= res_ins;
					evicted       <= res_evc;
					evicted_addr  <= res_old;
					if (res_ins) begin
						fill_q <= fill_q + CNT_W'(1);
					end
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

### rtl/core/ctue_checker.sv
// Port-level checks for the contact table unit, bound to its top level.
`default_nettype none
module ctue_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        done,
	input wire logic        hit,
	input wire logic        inserted,
	input wire logic        evicted,
	input wire logic [15:0] evicted_addr
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transfer did not make the unit busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while still busy");

	a_hit_no_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		(done && hit) |-> (!inserted && !evicted))
		else $error("hit result also reports an allocation");

	a_evict_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !evicted) |-> (evicted_addr == 16'd0))
		else $error("evicted address nonzero without eviction");

endmodule

bind contact_table_upsert_evict_unit ctue_checker u_ctue_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.hit          (hit),
	.inserted     (inserted),
	.evicted      (evicted),
	.evicted_addr (evicted_addr)
);
`default_nettype wire
